>>> sv/smpq_pkg.sv
// Shared widths, status codes and cell types for the sorted min priority queue.
package smpq_pkg;

	localparam int WEIGHT_W     = 32;
	localparam int TAG_W        = 9;
	localparam int STATUS_W     = 2;
	localparam int OCC_W        = 9;
	localparam int CAPACITY_DEF = 256;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_GET    = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [WEIGHT_W-1:0] weight;
		logic [TAG_W-1:0]    tag;
	} slot_t;

	// Broadcast to every cell in the cycle a beat is taken.
	typedef struct packed {
		logic  ins;
		logic  get;
		slot_t item;
	} cell_cmd_t;

endpackage

>>> sv/smpq_cell.sv
// One slot of the sorted chain: compares against a new entry and shifts left or right.
module smpq_cell (
	input  logic               clk,
	input  smpq_pkg::cell_cmd_t cmd,
	input  logic               occ,
	input  logic               prev_occ,
	input  logic               prev_shift,
	input  smpq_pkg::slot_t    prev_slot,
	input  smpq_pkg::slot_t    next_slot,
	output logic               shift,
	output smpq_pkg::slot_t    slot
);

	smpq_pkg::slot_t slot_q;
	logic            ins_here;

	// Held entry moves right when the new one sorts at or ahead of it (ties LIFO).
	assign shift    = occ && (cmd.item.weight <= slot_q.weight);
	// New entry lands in the first cell that either shifts or is free.
	assign ins_here = prev_occ && !prev_shift && (!occ || shift);
	assign slot     = slot_q;

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (prev_shift) begin
				slot_q <= prev_slot;
			end else if (ins_here) begin
				slot_q <= cmd.item;
			end
		end else if (cmd.get) begin
			slot_q <= next_slot;
		end
	end

endmodule

>>> sv/sorted_min_priority_queue.sv
// Sorted min priority queue built as a chain of compare-and-shift cells.
// A result beat is registered in the cycle after its input beat is accepted.
// Throughput: one operation per cycle unless stalled; all cells check the new entry at once.
// Input stalls only while the result register is full and the output side stalls.
// Reset (arst_n low) empties the queue and the result register; slot contents are not cleared.
module sorted_min_priority_queue #(
	parameter int CAPACITY = smpq_pkg::CAPACITY_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           op,
	input  logic [smpq_pkg::WEIGHT_W-1:0]  weight,
	input  logic [smpq_pkg::TAG_W-1:0]     tag,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [smpq_pkg::STATUS_W-1:0]  status,
	output logic [smpq_pkg::WEIGHT_W-1:0]  out_weight,
	output logic [smpq_pkg::TAG_W-1:0]     out_tag,
	output logic [smpq_pkg::OCC_W-1:0]     occupancy
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic [CW-1:0]             count_q;
	logic [CW-1:0]             count_nxt;
	logic                      accept;
	logic                      full;
	logic                      empty;
	smpq_pkg::cell_cmd_t       cmd;
	logic [CAPACITY-1:0]       occ;
	logic [CAPACITY-1:0]       shift;
	smpq_pkg::slot_t           slots [CAPACITY];
	logic [CW+smpq_pkg::OCC_W-1:0] count_ext;

	logic                          out_valid_q;
	logic [smpq_pkg::STATUS_W-1:0] status_q;
	logic [smpq_pkg::WEIGHT_W-1:0] weight_q;
	logic [smpq_pkg::TAG_W-1:0]    tag_q;
	logic [smpq_pkg::OCC_W-1:0]    occ_q;

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign full     = (count_q == CW'(CAPACITY));
	assign empty    = (count_q == '0);

	assign cmd.ins         = accept && (op == smpq_pkg::OP_INSERT) && !full;
	assign cmd.get         = accept && (op == smpq_pkg::OP_GET) && !empty;
	assign cmd.item.weight = weight;
	assign cmd.item.tag    = tag;

	always_comb begin
		count_nxt = count_q;
		if (cmd.ins) begin
			count_nxt = count_q + CW'(1);
		end else if (cmd.get) begin
			count_nxt = count_q - CW'(1);
		end
	end

	assign count_ext = {{smpq_pkg::OCC_W{1'b0}}, count_nxt};

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		smpq_pkg::slot_t next_slot;
		logic            prev_occ;
		logic            prev_shift;
		smpq_pkg::slot_t prev_slot;

		assign occ[i] = (count_q > CW'(i));

		if (i == 0) begin : g_head
			assign prev_occ   = 1'b1;
			assign prev_shift = 1'b0;
			assign prev_slot  = '0;
		end else begin : g_body
			assign prev_occ   = occ[i-1];
			assign prev_shift = shift[i-1];
			assign prev_slot  = slots[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign next_slot = '0;
		end else begin : g_mid
			assign next_slot = slots[i+1];
		end

		smpq_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.occ        (occ[i]),
			.prev_occ   (prev_occ),
			.prev_shift (prev_shift),
			.prev_slot  (prev_slot),
			.next_slot  (next_slot),
			.shift      (shift[i]),
			.slot       (slots[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result beat payload
	always_ff @(posedge clk) begin
		if (accept) begin
			occ_q <= count_ext[smpq_pkg::OCC_W-1:0];
			if (cmd.get) begin
				status_q <= smpq_pkg::ST_OK;
				weight_q <= slots[0].weight;
				tag_q    <= slots[0].tag;
			end else begin
				weight_q <= '0;
				tag_q    <= '0;
				if (op == smpq_pkg::OP_GET) begin
					status_q <= smpq_pkg::ST_EMPTY;
				end else if (full) begin
					status_q <= smpq_pkg::ST_FULL;
				end else begin
					status_q <= smpq_pkg::ST_OK;
				end
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign out_weight = weight_q;
	assign out_tag    = tag_q;
	assign occupancy  = occ_q;

endmodule

>>> bench/sorted_min_priority_queue_test.sv
// Self-checking bench for the sorted min priority queue: random traffic, stalls and back-pressure.
module sorted_min_priority_queue_test;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAPACITY       = smpq_pkg::CAPACITY_DEF;
	localparam int RANDOM_OPS     = 1950;
	localparam int HOLD_CYCLES    = 450;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int MAX_REPORTS    = 10;

	typedef struct packed {
		logic                          op;
		logic [smpq_pkg::WEIGHT_W-1:0] weight;
		logic [smpq_pkg::TAG_W-1:0]    tag;
	} req_t;

	typedef struct packed {
		logic [smpq_pkg::STATUS_W-1:0] status;
		logic [smpq_pkg::WEIGHT_W-1:0] out_weight;
		logic [smpq_pkg::TAG_W-1:0]    out_tag;
		logic [smpq_pkg::OCC_W-1:0]    occupancy;
	} result_t;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          in_valid  = 1'b0;
	logic                          op        = smpq_pkg::OP_INSERT;
	logic [smpq_pkg::WEIGHT_W-1:0] weight    = '0;
	logic [smpq_pkg::TAG_W-1:0]    tag       = '0;
	logic                          out_stall = 1'b0;
	logic                          in_stall;
	logic                          out_valid;
	logic [smpq_pkg::STATUS_W-1:0] status;
	logic [smpq_pkg::WEIGHT_W-1:0] out_weight;
	logic [smpq_pkg::TAG_W-1:0]    out_tag;
	logic [smpq_pkg::OCC_W-1:0]    occupancy;

	// sorted copy of the queue contents, head first
	smpq_pkg::slot_t held[$];
	req_t    pending_ops[$];
	result_t expected_results[$];
	req_t    next_op;

	logic    in_steady  = 1'b0;
	logic    out_steady = 1'b0;
	logic    holding    = 1'b0;
	int      steady_left;
	int      in_gap;
	int      stall_left;
	int      quiet_cycles;

	int      ops_queued     = 0;
	int      ops_taken      = 0;
	int      results_seen   = 0;
	int      mismatches     = 0;
	int      full_refusals  = 0;
	int      empty_gets     = 0;
	int      peak_entries   = 0;
	int      held_back      = 0;

	sorted_min_priority_queue #(
		.CAPACITY(CAPACITY)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.weight    (weight),
		.tag       (tag),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.out_weight(out_weight),
		.out_tag   (out_tag),
		.occupancy (occupancy)
	);

	always #4 clk = ~clk;

	// Applies one operation to the local copy and returns the result beat it should give.
	function automatic result_t apply_op(input req_t req);
		result_t         res;
		smpq_pkg::slot_t entry;
		int              pos;
		res = '0;
		res.status = smpq_pkg::ST_OK;
		if (req.op == smpq_pkg::OP_INSERT) begin
			if (held.size() >= CAPACITY) begin
				res.status = smpq_pkg::ST_FULL;
				full_refusals++;
			end else begin
				// ahead of the first entry not lighter than the new one: ties go LIFO
				pos = 0;
				while (pos < held.size() && held[pos].weight < req.weight)
					pos++;
				entry.weight = req.weight;
				entry.tag = req.tag;
				held.insert(pos, entry);
			end
		end else if (held.size() == 0) begin
			res.status = smpq_pkg::ST_EMPTY;
			empty_gets++;
		end else begin
			entry = held.pop_front();
			res.out_weight = entry.weight;
			res.out_tag = entry.tag;
		end
		if (held.size() > peak_entries)
			peak_entries = held.size();
		res.occupancy = smpq_pkg::OCC_W'(held.size());
		return res;
	endfunction

	// Mostly short gaps, now and then a long one; none during a steady stretch.
	function automatic int pick_gap(input logic steady);
		int roll;
		if (steady)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 45)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Small values give plenty of equal weights; the ends of the range turn up often.
	function automatic logic [smpq_pkg::WEIGHT_W-1:0] pick_weight();
		case ($urandom_range(0, 9))
			0: return $urandom_range(0, 1) ? '1 : '0;
			1, 2, 3: return $urandom_range(0, 7);
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_op(input logic kind, input logic [smpq_pkg::WEIGHT_W-1:0] w,
			input logic [smpq_pkg::TAG_W-1:0] t);
		req_t req;
		req.op = kind;
		req.weight = w;
		req.tag = t;
		pending_ops.push_back(req);
		ops_queued++;
	endtask

	task automatic flag_error(input string what, input longint unsigned want,
			input longint unsigned got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("mismatch on result %0d: %s expected 0x%0h, got 0x%0h",
				results_seen, what, want, got);
	endtask

	// switches both sides between stretches with and without idling
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steady_left <= 0;
			in_steady <= 1'b0;
			out_steady <= 1'b0;
		end else if (steady_left == 0) begin
			steady_left <= $urandom_range(100, 400);
			in_steady <= ($urandom_range(0, 3) == 0);
			out_steady <= ($urandom_range(0, 3) == 0);
		end else begin
			steady_left <= steady_left - 1;
		end
	end

	// input side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			op <= smpq_pkg::OP_INSERT;
			weight <= '0;
			tag <= '0;
			in_gap <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_results.push_back(apply_op('{op, weight, tag}));
				ops_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (in_gap != 0) begin
					in_gap <= in_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_ops.size() != 0) begin
					next_op = pending_ops.pop_front();
					in_valid <= 1'b1;
					op <= next_op.op;
					weight <= next_op.weight;
					tag <= next_op.tag;
					in_gap <= pick_gap(in_steady);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output side stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (holding) begin
			out_stall <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			stall_left <= pick_gap(out_steady);
		end
	end

	// long hold-off on the result side while the sender keeps offering beats
	initial begin
		while (ops_taken < 700)
			@(posedge clk);
		holding <= 1'b1;
		repeat (HOLD_CYCLES)
			@(posedge clk);
		holding <= 1'b0;
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && in_valid && in_stall)
			held_back++;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				flag_error("result beat with nothing pending, status", 0, status);
			end else begin
				if (status !== expected_results[0].status)
					flag_error("status", expected_results[0].status, status);
				if (out_weight !== expected_results[0].out_weight)
					flag_error("out_weight", expected_results[0].out_weight, out_weight);
				if (out_tag !== expected_results[0].out_tag)
					flag_error("out_tag", expected_results[0].out_tag, out_tag);
				if (occupancy !== expected_results[0].occupancy)
					flag_error("occupancy", expected_results[0].occupancy, occupancy);
				void'(expected_results.pop_front());
			end
			results_seen++;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat for %0d cycles, %0d results outstanding",
				quiet_cycles, expected_results.size());
			$display("end of test: mismatches");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int pct_choice[5];
		int done_random;
		int round;
		int ins_pct;
		int run;
		pct_choice = '{10, 40, 55, 70, 95};

		// directed: empty gets, extremes, equal weights, full drain past empty
		queue_op(smpq_pkg::OP_GET, '0, '0);
		queue_op(smpq_pkg::OP_GET, '1, '1);
		queue_op(smpq_pkg::OP_INSERT, 32'd100, 9'd1);
		queue_op(smpq_pkg::OP_INSERT, 32'd100, 9'd2);
		queue_op(smpq_pkg::OP_INSERT, 32'd100, 9'd3);
		queue_op(smpq_pkg::OP_INSERT, '1, 9'h1FF);
		queue_op(smpq_pkg::OP_INSERT, '1, 9'd7);
		queue_op(smpq_pkg::OP_INSERT, '0, 9'h000);
		queue_op(smpq_pkg::OP_INSERT, '0, 9'h0AA);
		queue_op(smpq_pkg::OP_INSERT, 32'd99, 9'h155);
		queue_op(smpq_pkg::OP_INSERT, 32'd101, 9'd9);
		repeat (10)
			queue_op(smpq_pkg::OP_GET, $urandom,
				smpq_pkg::TAG_W'($urandom_range(0, 511)));

		// random: fill past capacity, drain past empty, then mixed rounds
		done_random = 0;
		round = 0;
		while (done_random < RANDOM_OPS) begin
			if (round == 0) begin
				ins_pct = 95;
				run = 330;
			end else if (round == 1) begin
				ins_pct = 5;
				run = 330;
			end else begin
				ins_pct = pct_choice[$urandom_range(0, 4)];
				run = $urandom_range(60, 250);
			end
			repeat (run) begin
				queue_op(($urandom_range(0, 99) < ins_pct) ? smpq_pkg::OP_INSERT
					: smpq_pkg::OP_GET,
					pick_weight(), smpq_pkg::TAG_W'($urandom_range(0, 511)));
				done_random++;
			end
			round++;
		end

		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;

		while (ops_taken < ops_queued)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);

		$display("%0d operations checked over %0d results; %0d inserts refused when full, "
			, ops_taken, results_seen, full_refusals);
		$display("%0d gets on an empty queue, peak occupancy %0d of %0d, input stalled %0d cycles",
			empty_gets, peak_entries, CAPACITY, held_back);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
